/* hw/rtl/nand_hamming_ecc_generator_defines.svh */
// Assertion macros shared by the ECC generator RTL.
`ifndef NAND_HAMMING_ECC_GENERATOR_DEFINES_SVH
`define NAND_HAMMING_ECC_GENERATOR_DEFINES_SVH

// The condition implies the check in the same cycle.
`define NHECC_ASSERT_SAME(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
    else $error(msg);

// The condition implies the check in the next cycle.
`define NHECC_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
    else $error(msg);

`endif

/* hw/rtl/nhecc_pkg.sv */
`default_nettype none
package nhecc_pkg;

  localparam int DATA_W    = 32;
  localparam int HALF_W    = 12;
  localparam int ECC_W     = 2 * HALF_W;
  localparam int WORDS_MAX = 128;
  localparam int IDX_W     = (WORDS_MAX > 1) ? $clog2(WORDS_MAX) : 1;
  localparam int ROW_SHIFT = 5;

  localparam logic [DATA_W-1:0] FOLD_M8 = 32'h00ff00ff & 32'h00ffffff;
  localparam logic [DATA_W-1:0] FOLD_M4 = 32'h0f0f0f0f & 32'h000f0fff;
  localparam logic [DATA_W-1:0] FOLD_M2 = 32'h33333333 & 32'h0003033f;
  localparam logic [DATA_W-1:0] FOLD_M1 = 32'h55555555 & 32'h00010117;

  typedef struct packed {
    logic              valid;
    logic [ECC_W-1:0]  code;
  } nhecc_res_t;

endpackage
`default_nettype wire

/* hw/rtl/nhecc_accum.sv */
`default_nettype none
module nhecc_accum
  import nhecc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              word_fire,
  input  wire logic [DATA_W-1:0] word_data,
  input  wire logic              word_last,
  output nhecc_res_t             res
);

  logic [DATA_W-1:0] column_xor_r, column_xor_nxt, cx_sum;
  logic [HALF_W-1:0] row_acc_r, row_acc_nxt, acc_sum;
  logic [IDX_W-1:0]  word_idx_r, word_idx_nxt, idx_sum;
  logic [DATA_W-1:0] v1, v2, v3, v4, v5;
  logic [HALF_W-1:0] code;
  logic [ECC_W-1:0]  packed_code;

  always_comb begin
    cx_sum = column_xor_r ^ word_data;
    if (^word_data) begin
      acc_sum = row_acc_r ^ HALF_W'({word_idx_r, {ROW_SHIFT{1'b0}}});
    end else begin
      acc_sum = row_acc_r;
    end
    if (32'(word_idx_r) >= 32'(WORDS_MAX - 1)) begin
      idx_sum = '0;
    end else begin
      idx_sum = word_idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    v1 = (cx_sum >> 16) ^ cx_sum;
    v2 = v1 ^ ((v1 >> 8) & FOLD_M8);
    v3 = v2 ^ ((v2 >> 4) & FOLD_M4);
    v4 = v3 ^ ((v3 >> 2) & FOLD_M2);
    v5 = v4 ^ ((v4 >> 1) & FOLD_M1);
    code = acc_sum ^ HALF_W'({v5[16], v5[8], v5[4], v5[2], v5[1]});
    packed_code = {code, code ^ {HALF_W{v5[0]}}};
    res.valid = word_fire && word_last;
    res.code  = ~packed_code;
  end

  always_comb begin
    column_xor_nxt = column_xor_r;
    row_acc_nxt    = row_acc_r;
    word_idx_nxt   = word_idx_r;
    if (word_fire) begin
      if (word_last) begin
        column_xor_nxt = '0;
        row_acc_nxt    = '0;
        word_idx_nxt   = '0;
      end else begin
        column_xor_nxt = cx_sum;
        row_acc_nxt    = acc_sum;
        word_idx_nxt   = idx_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_xor_r <= '0;
      row_acc_r    <= '0;
      word_idx_r   <= '0;
    end else begin
      column_xor_r <= column_xor_nxt;
      row_acc_r    <= row_acc_nxt;
      word_idx_r   <= word_idx_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/nhecc_out_reg.sv */
`default_nettype none
module nhecc_out_reg
  import nhecc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  nhecc_res_t            res,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [ECC_W-1:0]      out_tdata   // ecc_value[23:0]
);

  logic             out_valid_r, out_valid_nxt;
  logic [ECC_W-1:0] out_data_r, out_data_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.code;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* hw/rtl/nand_hamming_ecc_generator.sv */
// Channel   Signals                      Payload
// in        in_tvalid/in_tready          in_tdata = data_word, in_tlast = last_word
// out       out_tvalid/out_tready        out_tdata = ecc_value
//
// One word is accepted every cycle unless a last word is held for a stalled
// output; the input register feeds the XOR and parity accumulators.
// A code is shown on out_tvalid from the output register after its last word leaves the input register.
// Reset is synchronous and clears the accumulators and all valid flags.
// A stalled output only holds back a last word; ordinary words keep flowing.
`default_nettype none
`include "nand_hamming_ecc_generator_defines.svh"
module nand_hamming_ecc_generator
  import nhecc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // data_word[31:0]
  input  wire logic              in_tlast,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [ECC_W-1:0]       out_tdata   // ecc_value[23:0]
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [DATA_W-1:0] s1_data_r, s1_data_nxt;
  logic              s1_last_r, s1_last_nxt;
  logic              out_free;
  logic              s1_adv;
  nhecc_res_t        res;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_data_nxt  = s1_data_r;
    s1_last_nxt  = s1_last_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
      s1_data_nxt  = in_tdata;
      s1_last_nxt  = in_tlast;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r <= s1_data_nxt;
    s1_last_r <= s1_last_nxt;
  end

  nhecc_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_fire (s1_adv),
    .word_data (s1_data_r),
    .word_last (s1_last_r),
    .res       (res)
  );

  nhecc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `NHECC_ASSERT_NEXT(a_last_gives_code, s1_adv && s1_last_r, out_tvalid,
                     "last word gave no code")
  `NHECC_ASSERT_SAME(a_stall_holds_last,
                     s1_valid_r && s1_last_r && out_tvalid && !out_tready, !s1_adv,
                     "last word advanced over a pending code")
  `NHECC_ASSERT_SAME(a_busy_only_when_full, !in_tready, s1_valid_r && s1_last_r,
                     "input stalled without a held last word")

endmodule
`default_nettype wire
